// ===== rtl/core/sorted_insert_priority_queue_assert.svh =====
// assertion macros for the sorted insert priority queue
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SIPQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sipq assertion failed");

// next-cycle implication, disabled during reset
`define SIPQ_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sipq assertion failed");

`endif

// ===== rtl/core/sipq_pkg.sv =====
// types, constants and microcode table of the sorted insert priority queue
package sipq_pkg;

   localparam int DEPTH        = 16;
   localparam int PRIO_BITS    = 8;
   localparam int PAYLOAD_BITS = 32;

   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS = $clog2(3 * DEPTH);

   // port field widths
   localparam int REQ_PRIO_W    = 8;
   localparam int REQ_PAYLOAD_W = 32;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 5;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 48;

   // response word layout
   localparam int RSP_PRIO_LSB    = 0;
   localparam int RSP_PAYLOAD_LSB = 8;
   localparam int RSP_STATUS_LSB  = 40;
   localparam int RSP_FILL_LSB    = 42;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;
   typedef logic [SUM_BITS-1:0] sum_type;

   typedef struct packed {
      logic [PRIO_BITS-1:0]    prio;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   // request kinds
   localparam logic REQ_ENQ = 1'b0;
   localparam logic REQ_DEQ = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // jump conditions
   localparam logic [2:0] C_NONE     = 3'd0;
   localparam logic [2:0] C_ACCEPT   = 3'd1;
   localparam logic [2:0] C_DEQ      = 3'd2;
   localparam logic [2:0] C_FULL     = 3'd3;
   localparam logic [2:0] C_EMPTY    = 3'd4;
   localparam logic [2:0] C_STOP     = 3'd5;
   localparam logic [2:0] C_RSP_FREE = 3'd6;

   // when the datapath ops of a step take effect
   localparam logic [1:0] EX_ALWAYS    = 2'd0;
   localparam logic [1:0] EX_TAKEN     = 2'd1;
   localparam logic [1:0] EX_NOT_TAKEN = 2'd2;

   // position register ops
   localparam logic [1:0] POS_KEEP  = 2'd0;
   localparam logic [1:0] POS_COUNT = 2'd1;
   localparam logic [1:0] POS_ONE   = 2'd2;
   localparam logic [1:0] POS_DEC   = 2'd3;

   // store write ops
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_SHIFT = 2'd1;
   localparam logic [1:0] WR_NEW   = 2'd2;

   // response kinds
   localparam logic [2:0] RK_NONE  = 3'd0;
   localparam logic [2:0] RK_OK    = 3'd1;
   localparam logic [2:0] RK_FULL  = 3'd2;
   localparam logic [2:0] RK_EMPTY = 3'd3;
   localparam logic [2:0] RK_DATA  = 3'd4;

   // program steps
   localparam int PC_BITS = 4;
   localparam logic [PC_BITS-1:0] S_IDLE      = 4'd0;
   localparam logic [PC_BITS-1:0] S_DISPATCH  = 4'd1;
   localparam logic [PC_BITS-1:0] S_ENQ_CHK   = 4'd2;
   localparam logic [PC_BITS-1:0] S_SHIFT     = 4'd3;
   localparam logic [PC_BITS-1:0] S_WR_NEW    = 4'd4;
   localparam logic [PC_BITS-1:0] S_RSP_OK    = 4'd5;
   localparam logic [PC_BITS-1:0] S_RSP_FULL  = 4'd6;
   localparam logic [PC_BITS-1:0] S_DEQ_CHK   = 4'd7;
   localparam logic [PC_BITS-1:0] S_RSP_DATA  = 4'd8;
   localparam logic [PC_BITS-1:0] S_RSP_EMPTY = 4'd9;

   typedef struct packed {
      logic [2:0]         cond;
      logic [PC_BITS-1:0] target;
      logic               hold;
      logic [1:0]         ex;
      logic               accept;
      logic [1:0]         pos_op;
      logic [1:0]         wr_op;
      logic               cnt_inc;
      logic               pop;
      logic [2:0]         rsp_kind;
   } uop_type;

   // gated commands from sequencer to datapath
   typedef struct packed {
      logic       accept;
      logic [1:0] pos_op;
      logic [1:0] wr_op;
      logic       cnt_inc;
      logic       pop;
      logic [2:0] rsp_kind;
   } cmd_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic accept;
      logic is_deq;
      logic full;
      logic empty;
      logic stop;
      logic rsp_free;
   } flags_type;

   localparam uop_type UOP_NOP = '{
      cond: C_NONE, target: S_IDLE, hold: 1'b0, ex: EX_ALWAYS, accept: 1'b0,
      pos_op: POS_KEEP, wr_op: WR_NONE, cnt_inc: 1'b0, pop: 1'b0, rsp_kind: RK_NONE
   };

   function automatic uop_type ucode_rom(logic [PC_BITS-1:0] pc);
      uop_type w;
      w = UOP_NOP;
      unique case (pc)
         S_IDLE: begin
            w.cond   = C_ACCEPT;
            w.target = S_DISPATCH;
            w.hold   = 1'b1;
            w.accept = 1'b1;
            w.pos_op = POS_COUNT;
         end
         S_DISPATCH: begin
            w.cond   = C_DEQ;
            w.target = S_DEQ_CHK;
         end
         S_ENQ_CHK: begin
            w.cond   = C_FULL;
            w.target = S_RSP_FULL;
         end
         S_SHIFT: begin
            w.cond   = C_STOP;
            w.target = S_WR_NEW;
            w.hold   = 1'b1;
            w.ex     = EX_NOT_TAKEN;
            w.pos_op = POS_DEC;
            w.wr_op  = WR_SHIFT;
         end
         S_WR_NEW: begin
            w.wr_op   = WR_NEW;
            w.cnt_inc = 1'b1;
         end
         S_RSP_OK: begin
            w.cond     = C_RSP_FREE;
            w.target   = S_IDLE;
            w.hold     = 1'b1;
            w.ex       = EX_TAKEN;
            w.rsp_kind = RK_OK;
         end
         S_RSP_FULL: begin
            w.cond     = C_RSP_FREE;
            w.target   = S_IDLE;
            w.hold     = 1'b1;
            w.ex       = EX_TAKEN;
            w.rsp_kind = RK_FULL;
         end
         S_DEQ_CHK: begin
            w.cond   = C_EMPTY;
            w.target = S_RSP_EMPTY;
            w.pos_op = POS_ONE;
         end
         S_RSP_DATA: begin
            w.cond     = C_RSP_FREE;
            w.target   = S_IDLE;
            w.hold     = 1'b1;
            w.ex       = EX_TAKEN;
            w.pop      = 1'b1;
            w.rsp_kind = RK_DATA;
         end
         S_RSP_EMPTY: begin
            w.cond     = C_RSP_FREE;
            w.target   = S_IDLE;
            w.hold     = 1'b1;
            w.ex       = EX_TAKEN;
            w.rsp_kind = RK_EMPTY;
         end
         default: begin
            w.cond   = C_NONE;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

   // ring slot of head plus offset, offset below twice the depth
   function automatic idx_type slot_at(idx_type head, sum_type off);
      sum_type s;
      s = SUM_BITS'(head) + off;
      if (s >= SUM_BITS'(2 * DEPTH)) begin
         s = s - SUM_BITS'(2 * DEPTH);
      end else if (s >= SUM_BITS'(DEPTH)) begin
         s = s - SUM_BITS'(DEPTH);
      end
      return IDX_BITS'(s);
   endfunction

endpackage

// ===== rtl/core/sipq_seq.sv =====
// microcode sequencer: step counter, control store and jump logic
module sipq_seq (
   input  logic               clock,
   input  logic               reset,
   input  sipq_pkg::flags_type flags,
   output sipq_pkg::cmd_type   cmd
);

   logic [sipq_pkg::PC_BITS-1:0] pc_ff;
   logic [sipq_pkg::PC_BITS-1:0] pc_in;
   sipq_pkg::uop_type            uop;
   logic                         taken;
   logic                         exec;

   assign uop = sipq_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (uop.cond)
         sipq_pkg::C_NONE:     taken = 1'b0;
         sipq_pkg::C_ACCEPT:   taken = flags.accept;
         sipq_pkg::C_DEQ:      taken = flags.is_deq;
         sipq_pkg::C_FULL:     taken = flags.full;
         sipq_pkg::C_EMPTY:    taken = flags.empty;
         sipq_pkg::C_STOP:     taken = flags.stop;
         sipq_pkg::C_RSP_FREE: taken = flags.rsp_free;
         default:              taken = 1'b0;
      endcase
   end

   always_comb begin
      unique case (uop.ex)
         sipq_pkg::EX_ALWAYS:    exec = 1'b1;
         sipq_pkg::EX_TAKEN:     exec = taken;
         sipq_pkg::EX_NOT_TAKEN: exec = !taken;
         default:                exec = 1'b0;
      endcase
   end

   always_comb begin
      if (taken) begin
         pc_in = uop.target;
      end else if (uop.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + sipq_pkg::PC_BITS'(1);
      end
   end

   always_comb begin
      cmd.accept   = uop.accept;
      cmd.pos_op   = exec ? uop.pos_op : sipq_pkg::POS_KEEP;
      cmd.wr_op    = exec ? uop.wr_op : sipq_pkg::WR_NONE;
      cmd.cnt_inc  = exec & uop.cnt_inc;
      cmd.pop      = exec & uop.pop;
      cmd.rsp_kind = exec ? uop.rsp_kind : sipq_pkg::RK_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= sipq_pkg::S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/core/sipq_dp.sv =====
// datapath: entry store, ring pointers, shift position and response register
module sipq_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sipq_pkg::cmd_type                     cmd,
   output sipq_pkg::flags_type                   flags,
   input  logic                                  req_tvalid,
   input  logic [sipq_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sipq_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser
);

   sipq_pkg::entry_type mem [sipq_pkg::DEPTH];

   sipq_pkg::entry_type rd_ff;
   sipq_pkg::idx_type   head_ff;
   sipq_pkg::idx_type   head_in;
   sipq_pkg::cnt_type   count_ff;
   sipq_pkg::cnt_type   count_in;
   sipq_pkg::cnt_type   pos_ff;
   sipq_pkg::cnt_type   pos_in;
   logic                is_deq_ff;
   sipq_pkg::entry_type new_ff;

   logic                                 rsp_valid_ff;
   logic                                 rsp_flag_ff;
   logic [sipq_pkg::PRIO_BITS-1:0]       rsp_prio_ff;
   logic [sipq_pkg::PAYLOAD_BITS-1:0]    rsp_payload_ff;
   logic [sipq_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic [sipq_pkg::FILL_W-1:0]          rsp_fill_ff;

   logic              accept;
   logic              rsp_free;
   logic              rsp_load;
   sipq_pkg::idx_type rd_addr;
   sipq_pkg::idx_type wr_addr;
   logic              wr_en;
   sipq_pkg::entry_type wr_data;
   logic [sipq_pkg::STATUS_W-1:0] status;

   assign accept   = req_tvalid & cmd.accept;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = (cmd.rsp_kind != sipq_pkg::RK_NONE);

   // request present, only tested at the step that takes a word
   assign flags.accept   = req_tvalid;
   assign flags.is_deq   = (is_deq_ff == sipq_pkg::REQ_DEQ);
   assign flags.full     = (count_ff >= sipq_pkg::CNT_BITS'(sipq_pkg::DEPTH));
   assign flags.empty    = (count_ff == '0);
   assign flags.stop     = (pos_ff == '0) || !(new_ff.prio < rd_ff.prio);
   assign flags.rsp_free = rsp_free;

   always_comb begin
      case (cmd.pos_op)
         sipq_pkg::POS_COUNT: pos_in = count_ff;
         sipq_pkg::POS_ONE:   pos_in = sipq_pkg::CNT_BITS'(1);
         sipq_pkg::POS_DEC:   pos_in = pos_ff - sipq_pkg::CNT_BITS'(1);
         default:             pos_in = pos_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + sipq_pkg::CNT_BITS'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - sipq_pkg::CNT_BITS'(1);
      end
   end

   assign head_in = cmd.pop ? sipq_pkg::slot_at(head_ff, sipq_pkg::SUM_BITS'(1)) : head_ff;

   // entry just ahead of the position being filled
   assign rd_addr = sipq_pkg::slot_at(head_ff, sipq_pkg::SUM_BITS'(pos_in)
                                      + sipq_pkg::SUM_BITS'(sipq_pkg::DEPTH - 1));
   assign wr_addr = sipq_pkg::slot_at(head_ff, sipq_pkg::SUM_BITS'(pos_ff));
   assign wr_en   = (cmd.wr_op != sipq_pkg::WR_NONE);
   assign wr_data = (cmd.wr_op == sipq_pkg::WR_SHIFT) ? rd_ff : new_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      case (cmd.rsp_kind)
         sipq_pkg::RK_FULL:  status = sipq_pkg::ST_FULL;
         sipq_pkg::RK_EMPTY: status = sipq_pkg::ST_EMPTY;
         default:            status = sipq_pkg::ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (accept) begin
         is_deq_ff      <= req_tuser;
         new_ff.prio    <= sipq_pkg::PRIO_BITS'(req_tdata[sipq_pkg::REQ_PRIO_W-1:0]);
         new_ff.payload <= sipq_pkg::PAYLOAD_BITS'(
            req_tdata[sipq_pkg::REQ_PRIO_W +: sipq_pkg::REQ_PAYLOAD_W]);
      end
      if (rsp_load) begin
         rsp_flag_ff   <= (cmd.rsp_kind == sipq_pkg::RK_DATA);
         rsp_status_ff <= status;
         rsp_fill_ff   <= sipq_pkg::FILL_W'(count_in);
         if (cmd.rsp_kind == sipq_pkg::RK_DATA) begin
            rsp_prio_ff    <= rd_ff.prio;
            rsp_payload_ff <= rd_ff.payload;
         end else begin
            rsp_prio_ff    <= '0;
            rsp_payload_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_fill_ff,
                        rsp_status_ff,
                        sipq_pkg::REQ_PAYLOAD_W'(rsp_payload_ff),
                        sipq_pkg::REQ_PRIO_W'(rsp_prio_ff)};

endmodule

// ===== rtl/core/sorted_insert_priority_queue.sv =====
// top level of the sorted insert priority queue
// A bounded priority queue of DEPTH entries kept sorted by ascending priority.
// req channel: one word per request; tuser selects enqueue (0) or dequeue (1),
// tdata carries the priority and payload of an entry to insert.
// rsp channel: exactly one word per request; tuser flags a returned entry,
// tdata carries its priority and payload, a status code and the fill count.
// An enqueue walks from the tail toward the head, moving one larger entry per
// cycle through the single store write port (k entries moved, at most
// DEPTH - 1), then writes the new entry and answers. A dequeue, or a
// rejected request, goes from its check step straight to its response step.
// The microcode program sets this order of steps.
// The finished response sits in an output register; a new request is taken
// while it waits, and the program holds at its response step only if the
// previous word has still not been taken.
// Reset empties the queue and clears both channels; the store contents are
// left as they are and only live entries are ever read.
module sorted_insert_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // entry_prio, entry_payload
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_prio, out_payload, status, fill_count, zero pad
   output logic        rsp_tuser   // out_valid
);

   sipq_pkg::cmd_type   cmd;
   sipq_pkg::flags_type flags;

   sipq_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .cmd   (cmd)
   );

   sipq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = cmd.accept;

endmodule

// ===== rtl/core/sipq_chk.sv =====
// port checker for the sorted insert priority queue, bound to the top level
`include "sorted_insert_priority_queue_assert.svh"

module sipq_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic [sipq_pkg::STATUS_W-1:0] status;
   logic [sipq_pkg::FILL_W-1:0]   fill;

   assign status = rsp_tdata[sipq_pkg::RSP_STATUS_LSB +: sipq_pkg::STATUS_W];
   assign fill   = rsp_tdata[sipq_pkg::RSP_FILL_LSB +: sipq_pkg::FILL_W];

   `SIPQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `SIPQ_ASSERT_IMP(a_entry_ok, clock, reset, rsp_tvalid && rsp_tuser, status == sipq_pkg::ST_OK)
   `SIPQ_ASSERT_IMP(a_reject_zero, clock, reset, rsp_tvalid && (status != sipq_pkg::ST_OK), !rsp_tuser && (rsp_tdata[39:0] == 40'd0))
   `SIPQ_ASSERT_IMP(a_fill_range, clock, reset, rsp_tvalid, fill <= sipq_pkg::FILL_W'(sipq_pkg::DEPTH))

endmodule

bind sorted_insert_priority_queue sipq_chk u_sipq_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
